[src/rgb332_run_length_encoder_macros.svh]
// assertion macros for the checker file of the rgb332 run-length encoder
// no dependencies; include by bare file name
`ifndef RGB332_RUN_LENGTH_ENCODER_MACROS_SVH
`define RGB332_RUN_LENGTH_ENCODER_MACROS_SVH

// property checked while reset is low
`define RLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgb332 rle assertion failed");

// property checked on every edge, reset included
`define RLE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rgb332 rle assertion failed");

`endif

[src/rgb332rle_pkg.sv]
// shared types, constants and the colour reduction function of the rgb332 run-length encoder
// no dependencies
package rgb332rle_pkg;

   localparam logic [15:0] MAX_RUN = 16'hffff;

   // result queue sizing
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   // highest queue level at which a new transaction can be taken
   localparam logic [FIFO_LVL_W-1:0] READY_LEVEL_IDLE = FIFO_LVL_W'(FIFO_DEPTH - 2);
   localparam logic [FIFO_LVL_W-1:0] READY_LEVEL_BUSY = FIFO_LVL_W'(FIFO_DEPTH - 4);

   // number of records pushed in one cycle
   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [23:0] pixel_rgb;
      logic        last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] run_length;
      logic [7:0]  colour_332;
      logic        last_record;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } fifo_push_type;

   typedef struct packed {
      logic                  not_empty;
      logic [FIFO_LVL_W-1:0] level;
   } fifo_status_type;

   // rrrgggbb from the top bits of each channel
   function automatic logic [7:0] to_rgb332(input logic [23:0] px);
      return {px[23:21], px[15:13], px[7:6]};
   endfunction

endpackage

[src/rgb332rle_fifo.sv]
// result queue of the rgb332 run-length encoder: up to two writes and one read a cycle
// depends on rgb332rle_pkg
module rgb332rle_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  rgb332rle_pkg::fifo_push_type   push,
   input  logic                           pop,
   output rgb332rle_pkg::rsp_payload_type head,
   output rgb332rle_pkg::fifo_status_type status
);

   rgb332rle_pkg::rsp_payload_type mem_ff [rgb332rle_pkg::FIFO_DEPTH];

   logic [rgb332rle_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rgb332rle_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rgb332rle_pkg::FIFO_LVL_W-1:0] level_ff, level_in;
   logic [rgb332rle_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
   logic                                 do_pop;

   assign wr_ptr_next = wr_ptr_ff + rgb332rle_pkg::FIFO_PTR_W'(1);
   assign do_pop      = pop && (level_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rgb332rle_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_in = do_pop ? rd_ptr_ff + rgb332rle_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + rgb332rle_pkg::FIFO_LVL_W'(push.count)
                  - rgb332rle_pkg::FIFO_LVL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      case (push.count)
         rgb332rle_pkg::PUSH_ONE: begin
            mem_ff[wr_ptr_ff] <= push.first;
         end
         rgb332rle_pkg::PUSH_TWO: begin
            mem_ff[wr_ptr_ff]   <= push.first;
            mem_ff[wr_ptr_next] <= push.second;
         end
         default: begin
         end
      endcase
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (level_ff != '0);
   assign status.level     = level_ff;

endmodule

[src/rgb332_run_length_encoder.sv]
// top level of the rgb332 run-length encoder
// depends on rgb332rle_pkg and rgb332rle_fifo
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   req     | in        | req_valid / req_ready | pixel_rgb[23:0], last_pixel
//   rsp     | out       | rsp_valid / rsp_ready | run_length[15:0], colour_332, last_record
//
// one pixel transaction per cycle while req_ready is high: a pixel lands in the input register, then one
// compare and one 16-bit increment against the open run decide the records
// records go from the input register into an 8-entry queue; a pixel yields 0, 1 or 2
// req_ready drops while the queue could not absorb two records from each pixel in flight
// reset (synchronous, active high) discards any open run and empties the queue
// a stalled rsp side backs up into req only once the queue is nearly full
module rgb332_run_length_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rgb332rle_pkg::req_payload_type req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rgb332rle_pkg::rsp_payload_type rsp_data
);

   // input register
   logic                           s1_valid_ff, s1_valid_in;
   rgb332rle_pkg::req_payload_type s1_data_ff;

   // open run
   logic [7:0]  run_colour_ff, run_colour_in;
   logic [15:0] run_count_ff, run_count_in;

   // per-pixel decision
   logic [7:0]  pixel_colour;
   logic        run_open;
   logic        extend_run;
   logic        close_run;
   logic [7:0]  next_colour;
   logic [15:0] next_count;

   rgb332rle_pkg::fifo_push_type   push;
   rgb332rle_pkg::fifo_status_type fifo_status;
   rgb332rle_pkg::rsp_payload_type closed_rec;
   rgb332rle_pkg::rsp_payload_type flush_rec;

   // accept only when the queue can hold the worst case of the pixel in flight and this one
   assign req_ready = s1_valid_ff ? (fifo_status.level <= rgb332rle_pkg::READY_LEVEL_BUSY)
                                  : (fifo_status.level <= rgb332rle_pkg::READY_LEVEL_IDLE);

   assign s1_valid_in = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_data_ff <= req_data;
      end
   end

   // run decision
   always_comb begin
      pixel_colour = rgb332rle_pkg::to_rgb332(s1_data_ff.pixel_rgb);
      run_open     = (run_count_ff != '0);
      extend_run   = run_open && (pixel_colour == run_colour_ff)
                     && (run_count_ff < rgb332rle_pkg::MAX_RUN);
      // colour change or full run closes the open run
      close_run    = run_open && !extend_run;

      next_colour = extend_run ? run_colour_ff : pixel_colour;
      next_count  = extend_run ? run_count_ff + 16'd1 : 16'd1;

      closed_rec.run_length  = run_count_ff;
      closed_rec.colour_332  = run_colour_ff;
      closed_rec.last_record = 1'b0;

      flush_rec.run_length   = next_count;
      flush_rec.colour_332   = next_colour;
      flush_rec.last_record  = 1'b1;

      run_colour_in = run_colour_ff;
      run_count_in  = run_count_ff;
      push.count    = rgb332rle_pkg::PUSH_NONE;
      push.first    = closed_rec;
      push.second   = flush_rec;

      if (s1_valid_ff) begin
         run_colour_in = next_colour;
         // end of region: flush and leave no open run
         run_count_in  = s1_data_ff.last_pixel ? 16'd0 : next_count;
         if (close_run && s1_data_ff.last_pixel) begin
            push.count = rgb332rle_pkg::PUSH_TWO;
         end else if (close_run) begin
            push.count = rgb332rle_pkg::PUSH_ONE;
         end else if (s1_data_ff.last_pixel) begin
            push.count = rgb332rle_pkg::PUSH_ONE;
            push.first = flush_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_colour_ff <= '0;
         run_count_ff  <= '0;
      end else begin
         run_colour_ff <= run_colour_in;
         run_count_ff  <= run_count_in;
      end
   end

   // result queue; its head is the rsp payload
   rgb332rle_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_ready),
      .head   (rsp_data),
      .status (fifo_status)
   );

   assign rsp_valid = fifo_status.not_empty;

endmodule

[src/rgb332rle_checker.sv]
// port-level checks of the rgb332 run-length encoder, bound to the top level
// depends on rgb332rle_pkg and rgb332_run_length_encoder_macros.svh
`include "rgb332_run_length_encoder_macros.svh"

module rgb332rle_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input rgb332rle_pkg::rsp_payload_type rsp_data
);

   // a stalled record holds
   `RLE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // a record never has an empty run
   `RLE_ASSERT(a_len_nonzero, clock, reset, rsp_valid |-> rsp_data.run_length != 16'd0)

   // reset empties the queue
   `RLE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // with nothing queued or in flight a transaction is always taken
   `RLE_ASSERT(a_ready_idle, clock, reset, !rsp_valid && !$past(req_valid && req_ready) |-> req_ready)

endmodule

bind rgb332_run_length_encoder rgb332rle_checker u_checker (.*);

[sim/rgb332_run_length_encoder_tb.sv]
// self-checking testbench for the rgb332 run-length encoder: pixel streams in, run records checked
// depends on rgb332rle_pkg and the rgb332_run_length_encoder top level
`timescale 1ns / 1ps

module rgb332_run_length_encoder_tb;

   // cycles with no transaction on either channel before the run is called hung
   localparam int HANG_LIMIT = 1000;
   // settle time after the last record, well past the pipeline depth
   localparam int TAIL_CYCLES = 50;
   localparam int REPORT_LIMIT = 10;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   rgb332rle_pkg::req_payload_type req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   rgb332rle_pkg::rsp_payload_type rsp_data;

   // predictor state: the open run as the block should hold it
   logic [7:0]  open_colour = 8'h00;
   logic [15:0] open_count = 16'h0000;

   rgb332rle_pkg::rsp_payload_type expected_records[$];
   int error_count = 0;
   int hang_count = 0;

   // idling controls, switched by the test tasks
   bit pixel_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int stall_left = 0;

   rgb332_run_length_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // rrrgggbb from the top bits of each channel
   function automatic logic [7:0] reduce_colour(input logic [23:0] rgb);
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      red   = rgb[23:16];
      green = rgb[15:8];
      blue  = rgb[7:0];
      return (red & 8'he0) | ((green & 8'he0) >> 3) | (blue >> 6);
   endfunction

   // advance the open run by one accepted pixel and queue the records it closes
   function automatic void predict_runs(input rgb332rle_pkg::req_payload_type px);
      logic [7:0]                     colour;
      rgb332rle_pkg::rsp_payload_type rec;
      colour = reduce_colour(px.pixel_rgb);
      if (open_count != 16'd0 && colour == open_colour
          && open_count < rgb332rle_pkg::MAX_RUN) begin
         open_count = open_count + 16'd1;
      end else begin
         // colour change or full run closes the open run, if there is one
         if (open_count != 16'd0) begin
            rec.run_length  = open_count;
            rec.colour_332  = open_colour;
            rec.last_record = 1'b0;
            expected_records.push_back(rec);
         end
         open_colour = colour;
         open_count  = 16'd1;
      end
      // region end flushes whatever is open and leaves no run behind
      if (px.last_pixel) begin
         rec.run_length  = open_count;
         rec.colour_332  = open_colour;
         rec.last_record = 1'b1;
         expected_records.push_back(rec);
         open_count = 16'd0;
      end
   endfunction

   function automatic void note_error(input string what,
                                      input rgb332rle_pkg::rsp_payload_type want,
                                      input rgb332rle_pkg::rsp_payload_type got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%0t: %s: expected len %0d col %02h last %0b, got len %0d col %02h last %0b",
                  $realtime, what, want.run_length, want.colour_332, want.last_record,
                  got.run_length, got.colour_332, got.last_record);
   endfunction

   // monitor: predict on every pixel transaction, check every record transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            predict_runs(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_records.size() == 0) begin
               note_error("record with none expected", '0, rsp_data);
            end else begin
               if (rsp_data.run_length != expected_records[0].run_length ||
                   rsp_data.colour_332 != expected_records[0].colour_332 ||
                   rsp_data.last_record != expected_records[0].last_record)
                  note_error("record mismatch", expected_records[0], rsp_data);
               void'(expected_records.pop_front());
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   // record side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // random pixel of a given rgb332 colour, with the ignored low bits scrambled
   function automatic logic [23:0] colour_pixel(input logic [7:0] colour);
      logic [23:0] rgb;
      rgb = 24'($urandom);
      rgb[23:21] = colour[7:5];
      rgb[15:13] = colour[4:2];
      rgb[7:6]   = colour[1:0];
      return rgb;
   endfunction

   // one pixel transaction; called at a falling edge, returns at a falling edge
   // valid stays high on return so back-to-back calls stream without a gap when pixel gaps are off
   task automatic send_pixel(input logic [23:0] rgb, input logic last);
      if (pixel_gaps_on && $urandom_range(0, 11) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.pixel_rgb  <= rgb;
      req_data.last_pixel <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // one-pixel regions at the extremes, first of them straight after reset
   task automatic test_single_pixel_regions();
      send_pixel(24'hffffff, 1'b1);
      send_pixel(24'h000000, 1'b1);
      send_pixel(24'h1f1f3f, 1'b1);
      send_pixel(24'he0e0c0, 1'b1);
   endtask

   // runs extended by pixels differing only in dropped bits, closed by colour changes,
   // and a region whose last pixel changes colour so it yields two records
   task automatic test_colour_changes();
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'h1f1f3f, 1'b0);
      send_pixel(24'he0e0c0, 1'b0);
      send_pixel(24'hffffff, 1'b0);
      send_pixel(24'h200000, 1'b0);
      send_pixel(24'h400000, 1'b1);
   endtask

   // each kept bit of each channel alone, so a swapped or shifted field shows up
   task automatic test_channel_bits();
      send_pixel(24'h800000, 1'b0);
      send_pixel(24'h400000, 1'b0);
      send_pixel(24'h200000, 1'b0);
      send_pixel(24'h008000, 1'b0);
      send_pixel(24'h004000, 1'b0);
      send_pixel(24'h002000, 1'b0);
      send_pixel(24'h000080, 1'b0);
      send_pixel(24'h000040, 1'b0);
      send_pixel(24'h5a5a5a, 1'b1);
   endtask

   // regions built from runs of random colour and length, with some noise pixels
   // and stray region ends mixed in
   task automatic test_random_regions(input int pixel_total);
      int         sent;
      int         region_left;
      int         run_len;
      logic [7:0] colour;
      sent = 0;
      while (sent < pixel_total) begin
         if ($urandom_range(0, 6) == 0) begin
            send_pixel(24'($urandom), $urandom_range(0, 7) == 0);
            sent++;
         end else begin
            region_left = $urandom_range(1, 60);
            while (region_left > 0) begin
               colour = 8'($urandom_range(0, 255));
               run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                     : $urandom_range(1, 4);
               if (run_len > region_left) run_len = region_left;
               for (int i = 0; i < run_len; i++) begin
                  region_left--;
                  send_pixel(colour_pixel(colour), region_left == 0);
                  sent++;
               end
            end
         end
      end
   endtask

   // full-rate stream with no pixel gaps and no record back-pressure
   task automatic test_full_rate_stream(input int pixel_total);
      pixel_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      test_random_regions(pixel_total);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_pixel_regions();
      test_colour_changes();
      test_channel_bits();
      test_random_regions(500);
      test_random_regions(500);
      test_full_rate_stream(150);

      // stop the pixel stream, then let every record drain out
      req_valid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_records.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/rgb332rle_pkg.sv
src/rgb332rle_fifo.sv
src/rgb332_run_length_encoder.sv
src/rgb332rle_checker.sv
sim/rgb332_run_length_encoder_tb.sv
